[src/tll_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tll_pkg
// Shared constants, token kinds, keyword table and the command/status
// structs between the lexer controller and datapath.
// ----------------------------------------------------------------------------
package tll_pkg;

    localparam int LEXEME_DEPTH = 32;

    localparam logic [2:0] MODE_START   = 3'd0;
    localparam logic [2:0] MODE_NUM     = 3'd1;
    localparam logic [2:0] MODE_ID      = 3'd2;
    localparam logic [2:0] MODE_COLON   = 3'd3;
    localparam logic [2:0] MODE_COMMENT = 3'd4;

    localparam logic [4:0] K_ASSIGN  = 5'd8;
    localparam logic [4:0] K_EQUAL   = 5'd9;
    localparam logic [4:0] K_LESS    = 5'd10;
    localparam logic [4:0] K_PLUS    = 5'd11;
    localparam logic [4:0] K_MINUS   = 5'd12;
    localparam logic [4:0] K_TIMES   = 5'd13;
    localparam logic [4:0] K_DIVIDE  = 5'd14;
    localparam logic [4:0] K_LPAREN  = 5'd15;
    localparam logic [4:0] K_RPAREN  = 5'd16;
    localparam logic [4:0] K_SEMI    = 5'd17;
    localparam logic [4:0] K_NUM     = 5'd18;
    localparam logic [4:0] K_ID      = 5'd19;
    localparam logic [4:0] K_ENDFILE = 5'd20;
    localparam logic [4:0] K_ERROR   = 5'd21;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_TIMES  = 8'h2A;
    localparam logic [7:0] CH_DIVIDE = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    localparam int NUM_KW = 8;

    typedef struct packed {
        logic       latch;
        logic       append;
        logic       set_mode;
        logic [2:0] mode;
        logic       set_kind;
        logic [4:0] kind;
        logic       emit_rd;
        logic       emit_ld;
        logic       emit_empty;
        logic       done;
    } cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       eof;
        logic       is_digit;
        logic       is_letter;
        logic       is_colon;
        logic       is_equal;
        logic       is_space;
        logic       is_lbrace;
        logic       is_rbrace;
        logic       is_op;
        logic [4:0] op_kind;
        logic [4:0] word_kind;
        logic       len_zero;
        logic       idx_last;
        logic       out_free;
    } status_t;

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd0:    n = 3'd2;
            3'd1:    n = 3'd4;
            3'd2:    n = 3'd4;
            3'd3:    n = 3'd3;
            3'd4:    n = 3'd6;
            3'd5:    n = 3'd5;
            3'd6:    n = 3'd4;
            3'd7:    n = 3'd5;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
        logic [47:0] w;
        logic [2:0]  sel;
        case (k)
            3'd0:    w = 48'("if");
            3'd1:    w = 48'("then");
            3'd2:    w = 48'("else");
            3'd3:    w = 48'("end");
            3'd4:    w = 48'("repeat");
            3'd5:    w = 48'("until");
            3'd6:    w = 48'("read");
            3'd7:    w = 48'("write");
            default: w = 48'd0;
        endcase
        sel = kw_len(k) - 3'd1 - pos;
        return w[{sel, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

[src/tll_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tll_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[src/tll_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tll_ctrl
// Scanner sequencer: takes a character, steps the scan mode, and walks the
// lexeme store to emit a token's results.
// ----------------------------------------------------------------------------
module tll_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire tll_pkg::status_t st,
    output tll_pkg::cmd_t         cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FIRST   = 3'd1;
    localparam logic [2:0] S_START   = 3'd2;
    localparam logic [2:0] S_EMIT_RD = 3'd3;
    localparam logic [2:0] S_EMIT_LD = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       ret_reg;
    logic       ret_next;
    logic       start_act;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign start_act = (state_reg == S_START) ||
                       ((state_reg == S_FIRST) && (st.mode == tll_pkg::MODE_START));

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        if (start_act)
        begin
            state_next = S_IDLE;
            if (st.eof)
            begin
                cmd.set_kind = 1'b1;
                cmd.kind     = tll_pkg::K_ENDFILE;
                ret_next     = 1'b0;
                state_next   = S_EMIT_RD;
            end
            else if (st.is_space)
            begin
                state_next = S_IDLE;
            end
            else if (st.is_lbrace)
            begin
                cmd.set_mode = 1'b1;
                cmd.mode     = tll_pkg::MODE_COMMENT;
            end
            else if (st.is_digit)
            begin
                cmd.append   = 1'b1;
                cmd.set_mode = 1'b1;
                cmd.mode     = tll_pkg::MODE_NUM;
            end
            else if (st.is_letter)
            begin
                cmd.append   = 1'b1;
                cmd.set_mode = 1'b1;
                cmd.mode     = tll_pkg::MODE_ID;
            end
            else if (st.is_colon)
            begin
                cmd.append   = 1'b1;
                cmd.set_mode = 1'b1;
                cmd.mode     = tll_pkg::MODE_COLON;
            end
            else if (st.is_op)
            begin
                cmd.set_kind = 1'b1;
                cmd.kind     = st.op_kind;
                ret_next     = 1'b0;
                state_next   = S_EMIT_RD;
            end
            else
            begin
                cmd.append   = 1'b1;
                cmd.set_kind = 1'b1;
                cmd.kind     = tll_pkg::K_ERROR;
                ret_next     = 1'b0;
                state_next   = S_EMIT_RD;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd.latch  = 1'b1;
                        state_next = S_FIRST;
                    end
                end
                S_FIRST:
                begin
                    state_next = S_IDLE;
                    case (st.mode)
                        tll_pkg::MODE_NUM:
                        begin
                            if (!st.eof && st.is_digit)
                            begin
                                cmd.append = 1'b1;
                            end
                            else
                            begin
                                cmd.set_kind = 1'b1;
                                cmd.kind     = tll_pkg::K_NUM;
                                ret_next     = 1'b1;
                                state_next   = S_EMIT_RD;
                            end
                        end
                        tll_pkg::MODE_ID:
                        begin
                            if (!st.eof && st.is_letter)
                            begin
                                cmd.append = 1'b1;
                            end
                            else
                            begin
                                cmd.set_kind = 1'b1;
                                cmd.kind     = st.word_kind;
                                ret_next     = 1'b1;
                                state_next   = S_EMIT_RD;
                            end
                        end
                        tll_pkg::MODE_COLON:
                        begin
                            cmd.set_kind = 1'b1;
                            state_next   = S_EMIT_RD;
                            if (!st.eof && st.is_equal)
                            begin
                                cmd.append = 1'b1;
                                cmd.kind   = tll_pkg::K_ASSIGN;
                                ret_next   = 1'b0;
                            end
                            else
                            begin
                                cmd.kind = tll_pkg::K_ERROR;
                                ret_next = 1'b1;
                            end
                        end
                        tll_pkg::MODE_COMMENT:
                        begin
                            if (st.eof)
                            begin
                                cmd.set_kind = 1'b1;
                                cmd.kind     = tll_pkg::K_ENDFILE;
                                ret_next     = 1'b0;
                                state_next   = S_EMIT_RD;
                            end
                            else if (st.is_rbrace)
                            begin
                                cmd.set_mode = 1'b1;
                                cmd.mode     = tll_pkg::MODE_START;
                            end
                        end
                        default:
                        begin
                            cmd.set_mode = 1'b1;
                            cmd.mode     = tll_pkg::MODE_START;
                        end
                    endcase
                end
                S_EMIT_RD:
                begin
                    if (st.len_zero)
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit_empty = 1'b1;
                            cmd.done       = 1'b1;
                            state_next     = ret_reg ? S_START : S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.emit_rd = 1'b1;
                        state_next  = S_EMIT_LD;
                    end
                end
                S_EMIT_LD:
                begin
                    if (st.out_free)
                    begin
                        cmd.emit_ld = 1'b1;
                        if (st.idx_last)
                        begin
                            cmd.done   = 1'b1;
                            state_next = ret_reg ? S_START : S_IDLE;
                        end
                        else
                        begin
                            state_next = S_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[src/tll_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tll_dp
// Scanner datapath: input latch, character classes, scan mode, lexeme store
// with keyword tracking, and the result output register.
// ----------------------------------------------------------------------------
module tll_dp #(
    parameter int LEXEME_DEPTH = tll_pkg::LEXEME_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [7:0]     ch,
    input  wire logic           end_mark,
    input  wire tll_pkg::cmd_t  cmd,
    output tll_pkg::status_t    st,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [4:0]          token_kind,
    output logic [7:0]          lex_char,
    output logic                lex_valid,
    output logic [4:0]          lex_index,
    output logic                too_long,
    output logic                last
);

    localparam int AW = $clog2(LEXEME_DEPTH);
    localparam int LW = $clog2(LEXEME_DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(LEXEME_DEPTH);

    logic [7:0]    ch_reg;
    logic          eof_reg;
    logic [2:0]    mode_reg;
    logic [2:0]    mode_next;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [7:0]    kmask_reg;
    logic [7:0]    kmask_next;
    logic [4:0]    kind_reg;
    logic          out_valid_reg;
    logic [4:0]    token_kind_reg;
    logic [7:0]    lex_char_reg;
    logic          lex_valid_reg;
    logic [4:0]    lex_index_reg;
    logic          too_long_reg;
    logic          last_reg;
    logic [7:0]    rdata;
    logic          room;
    logic          out_free;
    logic          idx_last;
    logic [7:0]    kmatch;
    logic [4:0]    word_kind;
    logic          is_op;
    logic [4:0]    op_kind;

    tll_ram #(
        .WIDTH (8),
        .DEPTH (LEXEME_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.append && room),
        .waddr (len_reg[AW-1:0]),
        .wdata (ch_reg),
        .re    (cmd.emit_rd),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign room     = (len_reg < DEPTH_L);
    assign out_free = !out_valid_reg || out_ready;
    assign idx_last = ((LW'(idx_reg) + LW'(1)) == len_reg);

    always_comb
    begin
        for (int k = 0; k < tll_pkg::NUM_KW; k++)
        begin
            kmatch[k] = (len_reg < LW'(tll_pkg::kw_len(3'(k)))) &&
                        (tll_pkg::kw_char(3'(k), len_reg[2:0]) == ch_reg);
        end
    end

    always_comb
    begin
        word_kind = tll_pkg::K_ID;
        for (int k = tll_pkg::NUM_KW - 1; k >= 0; k--)
        begin
            if (kmask_reg[k] && (len_reg == LW'(tll_pkg::kw_len(3'(k)))))
            begin
                word_kind = 5'(k);
            end
        end
        if (ovf_reg)
        begin
            word_kind = tll_pkg::K_ID;
        end
    end

    always_comb
    begin
        is_op   = 1'b1;
        op_kind = tll_pkg::K_ERROR;
        case (ch_reg)
            tll_pkg::CH_PLUS:   op_kind = tll_pkg::K_PLUS;
            tll_pkg::CH_MINUS:  op_kind = tll_pkg::K_MINUS;
            tll_pkg::CH_TIMES:  op_kind = tll_pkg::K_TIMES;
            tll_pkg::CH_DIVIDE: op_kind = tll_pkg::K_DIVIDE;
            tll_pkg::CH_EQUAL:  op_kind = tll_pkg::K_EQUAL;
            tll_pkg::CH_LESS:   op_kind = tll_pkg::K_LESS;
            tll_pkg::CH_LPAREN: op_kind = tll_pkg::K_LPAREN;
            tll_pkg::CH_RPAREN: op_kind = tll_pkg::K_RPAREN;
            tll_pkg::CH_SEMI:   op_kind = tll_pkg::K_SEMI;
            default:            is_op   = 1'b0;
        endcase
    end

    always_comb
    begin
        st           = '0;
        st.mode      = mode_reg;
        st.eof       = eof_reg;
        st.is_digit  = (ch_reg >= 8'h30) && (ch_reg <= 8'h39);
        st.is_letter = ((ch_reg >= 8'h61) && (ch_reg <= 8'h7A)) ||
                       ((ch_reg >= 8'h41) && (ch_reg <= 8'h5A));
        st.is_colon  = (ch_reg == tll_pkg::CH_COLON);
        st.is_equal  = (ch_reg == tll_pkg::CH_EQUAL);
        st.is_space  = (ch_reg == tll_pkg::CH_SPACE) || (ch_reg == tll_pkg::CH_TAB) ||
                       (ch_reg == tll_pkg::CH_NL);
        st.is_lbrace = (ch_reg == tll_pkg::CH_LBRACE);
        st.is_rbrace = (ch_reg == tll_pkg::CH_RBRACE);
        st.is_op     = is_op;
        st.op_kind   = op_kind;
        st.word_kind = word_kind;
        st.len_zero  = (len_reg == '0);
        st.idx_last  = idx_last;
        st.out_free  = out_free;
    end

    always_comb
    begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        kmask_next = kmask_reg;
        if (cmd.set_mode)
        begin
            mode_next = cmd.mode;
        end
        if (cmd.append)
        begin
            kmask_next = kmask_reg & kmatch;
            if (room)
            begin
                len_next = len_reg + LW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.emit_ld && !idx_last)
        begin
            idx_next = idx_reg + AW'(1);
        end
        if (cmd.done)
        begin
            mode_next  = tll_pkg::MODE_START;
            len_next   = '0;
            ovf_next   = 1'b0;
            idx_next   = '0;
            kmask_next = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= tll_pkg::MODE_START;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            kmask_reg     <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            kmask_reg <= kmask_next;
            if (cmd.emit_ld || cmd.emit_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            ch_reg  <= ch;
            eof_reg <= end_mark;
        end
        if (cmd.set_kind)
        begin
            kind_reg <= cmd.kind;
        end
        if (cmd.emit_ld)
        begin
            token_kind_reg <= kind_reg;
            lex_char_reg   <= rdata;
            lex_valid_reg  <= 1'b1;
            lex_index_reg  <= 5'(idx_reg);
            too_long_reg   <= ovf_reg;
            last_reg       <= idx_last;
        end
        else if (cmd.emit_empty)
        begin
            token_kind_reg <= kind_reg;
            lex_char_reg   <= 8'd0;
            lex_valid_reg  <= 1'b0;
            lex_index_reg  <= 5'd0;
            too_long_reg   <= 1'b0;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign token_kind = token_kind_reg;
    assign lex_char   = lex_char_reg;
    assign lex_valid  = lex_valid_reg;
    assign lex_index  = lex_index_reg;
    assign too_long   = too_long_reg;
    assign last       = last_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= DEPTH_L)
        else $error("lexeme length beyond store depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (len_reg == DEPTH_L))
        else $error("overflow flagged with room in store");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_ld || cmd.emit_empty) |-> out_free)
        else $error("result loaded over a pending transfer");

    a_full_append: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.append && !room && !cmd.done) |=> ovf_reg)
        else $error("append to full store did not flag overflow");

endmodule
`default_nettype wire

[src/tiny_language_lexer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tiny_language_lexer
// Scanner for the TINY language: one character or end mark per input
// transfer, one result transfer per stored lexeme character of each token, or one for a token with an empty lexeme.
// ----------------------------------------------------------------------------
// Sequence: an input is latched while idle and then classified; a finished token
//   alternates a registered store read and an output load per stored character,
//   an empty lexeme takes one load, and an input that ends one token and starts
//   another is taken up again after that token's last result. in_ready is high
//   only while idle, so no new input is taken until all results are loaded.
// Reset: rst_n clears mode, lexeme length, overflow and output valid at once;
//   store contents are left as they are.
module tiny_language_lexer #(
    parameter int LEXEME_DEPTH = tll_pkg::LEXEME_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] ch,
    input  wire logic       end_mark,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [4:0]      token_kind,
    output logic [7:0]      lex_char,
    output logic            lex_valid,
    output logic [4:0]      lex_index,
    output logic            too_long,
    output logic            last
);

    tll_pkg::cmd_t    cmd;
    tll_pkg::status_t st;

    tll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    tll_dp #(
        .LEXEME_DEPTH (LEXEME_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ch         (ch),
        .end_mark   (end_mark),
        .cmd        (cmd),
        .st         (st),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .token_kind (token_kind),
        .lex_char   (lex_char),
        .lex_valid  (lex_valid),
        .lex_index  (lex_index),
        .too_long   (too_long),
        .last       (last)
    );

endmodule
`default_nettype wire

[bench/tiny_language_lexer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_language_lexer_tb
// Drives TINY source text into the lexer one character or end mark per
// transfer and checks every lexeme result against a scanner model kept in
// the bench. A short directed program comes first. Random token streams
// follow: keywords, identifiers, numbers, operators, comments, blanks and
// error bytes, with long runs that overflow the lexeme store. Both sides
// idle in random bursts, and once the receiver holds off long enough to
// back up the input.
// ----------------------------------------------------------------------------
module tiny_language_lexer_tb;

    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          RANDOM_ITEMS   = 500;
    localparam int          CALM_ITEMS     = 440;
    localparam int          LONG_HOLD      = 300;
    localparam int          HOLD_AFTER     = 150;
    localparam logic [7:0]  CH_CR          = 8'h0D;

    typedef struct packed {
        logic [4:0] token_kind;
        logic [7:0] lex_char;
        logic       lex_valid;
        logic [4:0] lex_index;
        logic       too_long;
        logic       last;
    } lex_result_t;

    class lexer_scoreboard;
        logic [2:0]  mode;
        logic [7:0]  store [tll_pkg::LEXEME_DEPTH];
        int unsigned length;
        logic        overflow;
        string       keywords [tll_pkg::NUM_KW];
        lex_result_t lexeme_q [$];
        int unsigned errors, items, skipped;
        int unsigned results_seen, tokens_seen, truncated;
        logic [31:0] kinds_seen;

        function new();
            keywords = '{"if", "then", "else", "end", "repeat", "until", "read", "write"};
            mode = tll_pkg::MODE_START;
            length = 0;
            overflow = 1'b0;
            errors = 0;
            items = 0;
            skipped = 0;
            results_seen = 0;
            tokens_seen = 0;
            truncated = 0;
            kinds_seen = '0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == tll_pkg::CH_SPACE || c == tll_pkg::CH_TAB || c == tll_pkg::CH_NL;
        endfunction

        function void add_char(logic [7:0] c);
            if (length < tll_pkg::LEXEME_DEPTH)
            begin
                store[length] = c;
                length++;
            end
            else
                overflow = 1'b1;
        endfunction

        function logic [4:0] word_kind();
            bit hit;
            if (overflow)
                return tll_pkg::K_ID;
            for (int k = 0; k < tll_pkg::NUM_KW; k++)
            begin
                if (keywords[k].len() == length)
                begin
                    hit = 1'b1;
                    for (int i = 0; i < length; i++)
                        if (store[i] != keywords[k][i])
                            hit = 1'b0;
                    if (hit)
                        return 5'(k);
                end
            end
            return tll_pkg::K_ID;
        endfunction

        function void push_token(logic [4:0] kind);
            lex_result_t r;
            if (length == 0)
            begin
                r = '{kind, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1};
                lexeme_q.push_back(r);
            end
            else
            begin
                for (int i = 0; i < length; i++)
                begin
                    r.token_kind = kind;
                    r.lex_char   = store[i];
                    r.lex_valid  = 1'b1;
                    r.lex_index  = 5'(i);
                    r.too_long   = overflow;
                    r.last       = (i == length - 1);
                    lexeme_q.push_back(r);
                end
            end
            length = 0;
            overflow = 1'b0;
            mode = tll_pkg::MODE_START;
        endfunction

        function void start_char(logic [7:0] c, logic eof);
            if (eof)
            begin
                push_token(tll_pkg::K_ENDFILE);
                return;
            end
            if (is_blank(c))
                return;
            if (c == tll_pkg::CH_LBRACE)
                mode = tll_pkg::MODE_COMMENT;
            else if (is_digit(c))
            begin
                add_char(c);
                mode = tll_pkg::MODE_NUM;
            end
            else if (is_letter(c))
            begin
                add_char(c);
                mode = tll_pkg::MODE_ID;
            end
            else if (c == tll_pkg::CH_COLON)
            begin
                add_char(c);
                mode = tll_pkg::MODE_COLON;
            end
            else
            begin
                case (c)
                    tll_pkg::CH_PLUS:   push_token(tll_pkg::K_PLUS);
                    tll_pkg::CH_MINUS:  push_token(tll_pkg::K_MINUS);
                    tll_pkg::CH_TIMES:  push_token(tll_pkg::K_TIMES);
                    tll_pkg::CH_DIVIDE: push_token(tll_pkg::K_DIVIDE);
                    tll_pkg::CH_EQUAL:  push_token(tll_pkg::K_EQUAL);
                    tll_pkg::CH_LESS:   push_token(tll_pkg::K_LESS);
                    tll_pkg::CH_LPAREN: push_token(tll_pkg::K_LPAREN);
                    tll_pkg::CH_RPAREN: push_token(tll_pkg::K_RPAREN);
                    tll_pkg::CH_SEMI:   push_token(tll_pkg::K_SEMI);
                    default:
                    begin
                        add_char(c);
                        push_token(tll_pkg::K_ERROR);
                    end
                endcase
            end
        endfunction

        function void note_input(logic [7:0] c, logic eof);
            items++;
            if (!eof && (mode == tll_pkg::MODE_COMMENT ||
                         (mode == tll_pkg::MODE_START && is_blank(c))))
                skipped++;
            case (mode)
                tll_pkg::MODE_NUM:
                    if (!eof && is_digit(c))
                        add_char(c);
                    else
                    begin
                        push_token(tll_pkg::K_NUM);
                        start_char(c, eof);
                    end
                tll_pkg::MODE_ID:
                    if (!eof && is_letter(c))
                        add_char(c);
                    else
                    begin
                        push_token(word_kind());
                        start_char(c, eof);
                    end
                tll_pkg::MODE_COLON:
                    if (!eof && c == tll_pkg::CH_EQUAL)
                    begin
                        add_char(c);
                        push_token(tll_pkg::K_ASSIGN);
                    end
                    else
                    begin
                        push_token(tll_pkg::K_ERROR);
                        start_char(c, eof);
                    end
                tll_pkg::MODE_COMMENT:
                    if (eof)
                        push_token(tll_pkg::K_ENDFILE);
                    else if (c == tll_pkg::CH_RBRACE)
                        mode = tll_pkg::MODE_START;
                default:
                begin
                    mode = tll_pkg::MODE_START;
                    start_char(c, eof);
                end
            endcase
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(lex_result_t got);
            lex_result_t want;
            results_seen++;
            if (lexeme_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, actual %p", $time, got);
                return;
            end
            want = lexeme_q.pop_front();
            compare("token_kind", 8'(want.token_kind), 8'(got.token_kind));
            compare("lex_char", want.lex_char, got.lex_char);
            compare("lex_valid", 8'(want.lex_valid), 8'(got.lex_valid));
            compare("lex_index", 8'(want.lex_index), 8'(got.lex_index));
            compare("too_long", 8'(want.too_long), 8'(got.too_long));
            compare("last", 8'(want.last), 8'(got.last));
            if (want.last)
            begin
                tokens_seen++;
                kinds_seen[want.token_kind] = 1'b1;
                if (want.too_long)
                    truncated++;
            end
        endfunction

        function int pending();
            return lexeme_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  ch = 8'h00;
    logic        end_mark = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  token_kind;
    logic [7:0]  lex_char;
    logic        lex_valid;
    logic [4:0]  lex_index;
    logic        too_long;
    logic        last;
    bit          idle_on = 1'b1;

    lexer_scoreboard sb = new();

    tiny_language_lexer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .end_mark   (end_mark),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .token_kind (token_kind),
        .lex_char   (lex_char),
        .lex_valid  (lex_valid),
        .lex_index  (lex_index),
        .too_long   (too_long),
        .last       (last)
    );

    always #4 clk = ~clk;

    task automatic send_char(input logic [7:0] c, input logic eof);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        end_mark <= eof;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_input(c, eof);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    task automatic send_run(input bit digits);
        int unsigned n, pick;
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
        repeat (n)
        begin
            pick = $urandom_range(0, 51);
            if (digits)
                send_char(8'("0" + pick % 10), 1'b0);
            else if (pick < 26)
                send_char(8'("a" + pick), 1'b0);
            else
                send_char(8'("A" + pick - 26), 1'b0);
        end
    endtask

    // receiver: check each transfer, then pick the next ready value
    initial
    begin
        int unsigned stall_left;
        bit          held_long;
        lex_result_t seen;
        stall_left = 0;
        held_long = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                seen = '{token_kind, lex_char, lex_valid, lex_index, too_long, last};
                sb.check_result(seen);
            end
            if (!held_long && sb.results_seen >= HOLD_AFTER)
            begin
                held_long = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("tiny_language_lexer_tb NOT OK");
        $finish;
    end

    initial
    begin
        string       ops;
        string       word;
        logic [7:0]  b;
        int unsigned k;
        ops = "+-*/=<();";
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("{}if x:=0<9=(y)*-+/;:a");
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(tll_pkg::CH_RBRACE, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(8'($urandom), 1'b1);

        while (sb.items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3:
                begin
                    word = sb.keywords[$urandom_range(0, tll_pkg::NUM_KW - 1)];
                    if ($urandom_range(0, 5) == 0)
                        word = word.toupper();
                    send_text(word);
                end
                4, 5, 6:    send_run(1'b0);
                7, 8:       send_run(1'b1);
                9, 10, 11:  send_char(ops[$urandom_range(0, 8)], 1'b0);
                12:         send_text(":=");
                13:         send_char(tll_pkg::CH_COLON, 1'b0);
                14, 15:
                begin
                    k = $urandom_range(0, 2);
                    send_char(k == 0 ? tll_pkg::CH_SPACE :
                              (k == 1 ? tll_pkg::CH_TAB : tll_pkg::CH_NL), 1'b0);
                end
                16:
                begin
                    send_char(tll_pkg::CH_LBRACE, 1'b0);
                    repeat ($urandom_range(0, 6))
                    begin
                        do
                            b = 8'($urandom);
                        while (b == tll_pkg::CH_RBRACE);
                        send_char(b, 1'b0);
                    end
                    if ($urandom_range(0, 9) == 0)
                        send_char(8'($urandom), 1'b1);
                    send_char(tll_pkg::CH_RBRACE, 1'b0);
                end
                17:         send_char(8'($urandom_range(0, 255)), 1'b0);
                18:         send_char(8'($urandom), 1'b1);
                default:
                begin
                    k = $urandom_range(0, 2);
                    send_char(k == 0 ? CH_CR : (k == 1 ? tll_pkg::CH_RBRACE :
                              8'($urandom_range(128, 255))), 1'b0);
                end
            endcase
            if (sb.items > CALM_ITEMS)
                idle_on = 1'b0;
        end
        send_char(8'($urandom), 1'b1);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d characters and end marks, %0d of them blanks or comment text;",
                 sb.items, sb.skipped);
        $display("checked %0d results over %0d tokens of %0d kinds, %0d truncated.",
                 sb.results_seen, sb.tokens_seen, $countones(sb.kinds_seen), sb.truncated);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tiny_language_lexer_tb OK");
        else
            $display("tiny_language_lexer_tb NOT OK");
        $finish;
    end

endmodule
